// ----- rtl/core/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types, constants and helper functions shared by the decoder pipeline.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_TAG    = 8'h80;
    localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  LEAD2_TAG   = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD3_TAG   = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
    localparam logic [7:0]  LEAD4_TAG   = 8'hF0;
    localparam logic [7:0]  ASCII_MAX   = 8'h7F;

    localparam int          CP_W        = 21;
    localparam int          LEN_W       = 3;
    localparam int          AVAIL_W     = 3;

    localparam logic [CP_W-1:0]    MAX1      = 21'h00007F;
    localparam logic [CP_W-1:0]    MAX2      = 21'h0007FF;
    localparam logic [CP_W-1:0]    MAX3      = 21'h00FFFF;
    localparam logic [CP_W-1:0]    SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0]    SURR_HI   = 21'h00DFFF;
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = 3'd5;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_ASCII = 3'd1,
        KIND_TWO   = 3'd2,
        KIND_THREE = 3'd3,
        KIND_FOUR  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [6:0]   lead;
        logic [5:0]   c1;
        logic [5:0]   c2;
        logic [5:0]   c3;
        logic         pre_ok;
    } t_s1;

    typedef struct packed {
        t_kind             kind;
        logic [CP_W-1:0]   cp;
        logic              pre_ok;
    } t_s2;

    typedef struct packed {
        logic              valid_res;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_len;
    } t_res;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

endpackage

// ----- rtl/core/utf8d_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for byte windows and decoded characters.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
    logic                               valid;
    logic                               ready;
    logic [7:0]                         byte_0;
    logic [7:0]                         byte_1;
    logic [7:0]                         byte_2;
    logic [7:0]                         byte_3;
    logic [7:0]                         byte_4;
    logic [utf8d_pkg::AVAIL_W-1:0]      avail;

    modport source (output valid, byte_0, byte_1, byte_2, byte_3, byte_4, avail,
                    input ready);
    modport sink   (input valid, byte_0, byte_1, byte_2, byte_3, byte_4, avail,
                    output ready);
endinterface

interface utf8d_out_if;
    logic                               valid;
    logic                               ready;
    logic                               valid_res;
    logic [utf8d_pkg::CP_W-1:0]         code_point;
    logic [utf8d_pkg::LEN_W-1:0]        seq_len;

    modport source (output valid, valid_res, code_point, seq_len, input ready);
    modport sink   (input valid, valid_res, code_point, seq_len, output ready);
endinterface

// ----- rtl/core/utf8d_classify.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder, first stage
// Classifies the lead byte and checks the continuation bytes and the window
// length.
// ----------------------------------------------------------------------------
module utf8d_classify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf8d_in_if.sink          i_in,
    input  logic              i_ready,
    output logic              o_valid,
    output utf8d_pkg::t_s1    o_data
);

    logic                              r_valid;
    utf8d_pkg::t_s1                    r_data;
    utf8d_pkg::t_s1                    n_data;
    logic [utf8d_pkg::AVAIL_W-1:0]     w_n;
    logic                              w_c1;
    logic                              w_c2;
    logic                              w_c3;
    logic                              w_c4;
    logic                              w_take;

    assign w_take = !r_valid || i_ready;
    assign i_in.ready = w_take;

    always_comb begin
        w_n  = (i_in.avail > utf8d_pkg::AVAIL_MAX) ? utf8d_pkg::AVAIL_MAX : i_in.avail;
        w_c1 = utf8d_pkg::is_cont(i_in.byte_1);
        w_c2 = utf8d_pkg::is_cont(i_in.byte_2);
        w_c3 = utf8d_pkg::is_cont(i_in.byte_3);
        w_c4 = utf8d_pkg::is_cont(i_in.byte_4);
        n_data.lead   = i_in.byte_0[6:0];
        n_data.c1     = i_in.byte_1[5:0];
        n_data.c2     = i_in.byte_2[5:0];
        n_data.c3     = i_in.byte_3[5:0];
        n_data.kind   = utf8d_pkg::KIND_NONE;
        n_data.pre_ok = 1'b0;
        if (w_n != '0) begin
            priority if ((i_in.byte_0 & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_TAG) begin
                n_data.kind   = utf8d_pkg::KIND_TWO;
                n_data.pre_ok = (w_n >= 3'd2) && w_c1 && !((w_n > 3'd2) && w_c2);
            end else if ((i_in.byte_0 & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_TAG) begin
                n_data.kind   = utf8d_pkg::KIND_THREE;
                n_data.pre_ok = (w_n >= 3'd3) && w_c1 && w_c2 && !((w_n > 3'd3) && w_c3);
            end else if ((i_in.byte_0 & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_TAG) begin
                n_data.kind   = utf8d_pkg::KIND_FOUR;
                n_data.pre_ok = (w_n >= 3'd4) && w_c1 && w_c2 && w_c3
                                && !((w_n > 3'd4) && w_c4);
            end else if (i_in.byte_0 <= utf8d_pkg::ASCII_MAX) begin
                n_data.kind   = utf8d_pkg::KIND_ASCII;
                n_data.pre_ok = 1'b1;
            end else begin
                n_data.kind   = utf8d_pkg::KIND_NONE;
                n_data.pre_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/utf8d_assemble.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder, second stage
// Assembles the code point from the lead bits and the continuation payloads.
// ----------------------------------------------------------------------------
module utf8d_assemble (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utf8d_pkg::t_s1    i_data,
    output logic              o_ready,
    input  logic              i_ready,
    output logic              o_valid,
    output utf8d_pkg::t_s2    o_data
);

    logic              r_valid;
    utf8d_pkg::t_s2    r_data;
    utf8d_pkg::t_s2    n_data;
    logic              w_take;

    assign w_take  = !r_valid || i_ready;
    assign o_ready = w_take;

    always_comb begin
        n_data.kind   = i_data.kind;
        n_data.pre_ok = i_data.pre_ok;
        unique case (i_data.kind)
            utf8d_pkg::KIND_ASCII: n_data.cp = {14'd0, i_data.lead};
            utf8d_pkg::KIND_TWO:   n_data.cp = {10'd0, i_data.lead[4:0], i_data.c1};
            utf8d_pkg::KIND_THREE: n_data.cp = {5'd0, i_data.lead[3:0], i_data.c1,
                                                i_data.c2};
            utf8d_pkg::KIND_FOUR:  n_data.cp = {i_data.lead[2:0], i_data.c1, i_data.c2,
                                                i_data.c3};
            default:               n_data.cp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/utf8d_check.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder, third stage
// Rejects overlong forms and surrogates and drives the result register.
// ----------------------------------------------------------------------------
module utf8d_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utf8d_pkg::t_s2    i_data,
    output logic              o_ready,
    utf8d_out_if.source       o_out
);

    logic              r_valid;
    utf8d_pkg::t_res   r_data;
    utf8d_pkg::t_res   n_data;
    logic              w_range_ok;
    logic [utf8d_pkg::LEN_W-1:0] w_len;
    logic              w_take;

    assign w_take  = !r_valid || o_out.ready;
    assign o_ready = w_take;

    always_comb begin
        unique case (i_data.kind)
            utf8d_pkg::KIND_ASCII: begin
                w_range_ok = 1'b1;
                w_len      = 3'd1;
            end
            utf8d_pkg::KIND_TWO: begin
                w_range_ok = i_data.cp > utf8d_pkg::MAX1;
                w_len      = 3'd2;
            end
            utf8d_pkg::KIND_THREE: begin
                w_range_ok = (i_data.cp > utf8d_pkg::MAX2)
                             && !((i_data.cp >= utf8d_pkg::SURR_LO)
                                  && (i_data.cp <= utf8d_pkg::SURR_HI));
                w_len      = 3'd3;
            end
            utf8d_pkg::KIND_FOUR: begin
                w_range_ok = i_data.cp > utf8d_pkg::MAX3;
                w_len      = 3'd4;
            end
            default: begin
                w_range_ok = 1'b0;
                w_len      = '0;
            end
        endcase
        n_data.valid_res  = i_data.pre_ok && w_range_ok;
        n_data.code_point = n_data.valid_res ? i_data.cp : '0;
        n_data.seq_len    = n_data.valid_res ? w_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= n_data;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.valid_res  = r_data.valid_res;
    assign o_out.code_point = r_data.code_point;
    assign o_out.seq_len    = r_data.seq_len;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.valid_res) |-> (r_data.code_point == '0 && r_data.seq_len == '0))
        else $error("Rejected character carries a non-zero code point or length.");

    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.valid_res) |-> (r_data.seq_len != '0 && r_data.seq_len <= 3'd4))
        else $error("Accepted character has an impossible length.");

    a_no_surrogate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.valid_res)
        |-> !(r_data.code_point >= utf8d_pkg::SURR_LO && r_data.code_point <= utf8d_pkg::SURR_HI))
        else $error("Surrogate code point was accepted.");

    a_four_not_overlong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.valid_res && r_data.seq_len == 3'd4)
        |-> (r_data.code_point > utf8d_pkg::MAX3))
        else $error("Overlong four-byte form was accepted.");

endmodule

// ----- rtl/core/utf8_codepoint_decoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes one UTF-8 character at the start of a five-byte window.
// ----------------------------------------------------------------------------
// Each input transaction on i_in carries five window bytes and a count of
// the bytes present (values above five count as five). Each produces
// exactly one output transaction on o_out with a well-formed flag, the
// code point and the number of bytes the character takes; the last two
// are zero for a rejected window.
// The pipeline has three register stages: lead classification and
// continuation checks, code point assembly, and range checks into the
// output register. A transaction accepted on i_in passes through these
// registers in that order before it shows on o_out, and one transaction is
// accepted every cycle while the output is taken.
// When the receiver holds o_out.ready low, the output register holds and
// each stage still accepts while it is empty, so bubbles are squeezed out
// and nothing is lost or repeated; i_in.ready falls once all stages are
// full. A synchronous reset empties every stage.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8d_in_if.sink      i_in,
    utf8d_out_if.source   o_out
);

    logic              w_s1_valid;
    utf8d_pkg::t_s1    w_s1_data;
    logic              w_s2_ready;
    logic              w_s2_valid;
    utf8d_pkg::t_s2    w_s2_data;
    logic              w_s3_ready;

    utf8d_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (w_s2_ready),
        .o_valid (w_s1_valid),
        .o_data  (w_s1_data)
    );

    utf8d_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_data  (w_s1_data),
        .o_ready (w_s2_ready),
        .i_ready (w_s3_ready),
        .o_valid (w_s2_valid),
        .o_data  (w_s2_data)
    );

    utf8d_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .i_data  (w_s2_data),
        .o_ready (w_s3_ready),
        .o_out   (o_out)
    );

endmodule
